>>> hdl/awu_pkg.sv
// Shared types for the accumulator with undo history: request and status codes,
// and the command and status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package awu_pkg;

  localparam int TOTAL_W   = 32;
  localparam int REQ_W     = 3;
  localparam int COUNT_W   = 7;
  localparam int DIV_STEPS = 31;
  localparam int DCNT_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 3'd0,
    REQ_SUB  = 3'd1,
    REQ_MUL  = 3'd2,
    REQ_DIV  = 3'd3,
    REQ_UNDO = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DIV_ZERO   = 2'd1,
    ST_UNDO_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    exec_add;
    logic    exec_sub;
    logic    exec_mul;
    logic    mul_sat;
    logic    div_init;
    logic    div_step;
    logic    div_sat;
    logic    undo_read;
    logic    undo_load;
    logic    commit;
    logic    reply;
    status_t reply_status;
  } awu_cmd_t;

  typedef struct packed {
    logic opnd_zero;
    logic hist_empty;
  } awu_sts_t;

endpackage

>>> hdl/awu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module awu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/awu_datapath.sv
// Datapath: running total, operand, saturating add/subtract, multiplier,
// bit-serial divider, history pointers and the output word register.
// Depends on awu_pkg and awu_ram.
`timescale 1ns / 1ps

module awu_datapath import awu_pkg::*; #(
  parameter int HISTORY_DEPTH = 64,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  awu_cmd_t           cmd,
  output awu_sts_t           sts,
  input  logic [TOTAL_W-1:0] in_operand,
  output logic [TOTAL_W-1:0] out_total,
  output logic [1:0]         out_status,
  output logic [COUNT_W-1:0] out_count
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int NUM_W = TOTAL_W + FRAC_BITS;
  localparam int HI_W  = NUM_W - DIV_STEPS;

  localparam logic [TOTAL_W-1:0] T_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0] T_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  logic [TOTAL_W-1:0]   total_r, opnd_r, res_r;
  logic [2*TOTAL_W-1:0] prod_r;
  logic [TOTAL_W-1:0]   rem_r, dmag_r;
  logic [DIV_STEPS-1:0] lo_r, quo_r;
  logic                 ovf_r;
  logic [AW-1:0]        top_r;
  logic [CW-1:0]        fill_r;
  logic [TOTAL_W-1:0]   otot_r;
  logic [1:0]           ostat_r;
  logic [COUNT_W-1:0]   ocnt_r;

  logic [TOTAL_W-1:0]   mag_tot, mag_op, ram_rdata;
  logic                 neg;
  logic [TOTAL_W:0]     sum_c, dif_c, rem2, dext;
  logic [2*TOTAL_W-1:0] prod_c;
  logic [NUM_W-1:0]     num;
  logic [HI_W-1:0]      num_hi;
  logic                 ge;
  logic [AW-1:0]        top_inc, top_dec;

  // Signed value from a sign and a magnitude, clamped to the 32-bit range.
  function automatic logic [TOTAL_W-1:0] sat_mag(input logic s,
                                                 input logic [2*TOTAL_W-1:0] m);
    logic [TOTAL_W-1:0] r;
    if (s) begin
      r = (m >= {{TOTAL_W{1'b0}}, T_MIN}) ? T_MIN : (~m[TOTAL_W-1:0] + 1'b1);
    end else begin
      r = (m > {{TOTAL_W{1'b0}}, T_MAX}) ? T_MAX : m[TOTAL_W-1:0];
    end
    return r;
  endfunction

  assign mag_tot = total_r[TOTAL_W-1] ? (~total_r + 1'b1) : total_r;
  assign mag_op  = opnd_r[TOTAL_W-1] ? (~opnd_r + 1'b1) : opnd_r;
  assign neg     = total_r[TOTAL_W-1] ^ opnd_r[TOTAL_W-1];

  assign sum_c  = {total_r[TOTAL_W-1], total_r} + {opnd_r[TOTAL_W-1], opnd_r};
  assign dif_c  = {total_r[TOTAL_W-1], total_r} - {opnd_r[TOTAL_W-1], opnd_r};
  assign prod_c = mag_tot * mag_op;

  assign num    = {mag_tot, {FRAC_BITS{1'b0}}};
  assign num_hi = num[NUM_W-1:DIV_STEPS];

  assign dext = {1'b0, dmag_r};
  assign rem2 = {rem_r, lo_r[DIV_STEPS-1]};
  assign ge   = rem2 >= dext;

  assign top_inc = (top_r == AW'(HISTORY_DEPTH - 1)) ? '0 : top_r + 1'b1;
  assign top_dec = (top_r == '0) ? AW'(HISTORY_DEPTH - 1) : top_r - 1'b1;

  awu_ram #(
    .WIDTH(TOTAL_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(top_r),
    .wdata(total_r),
    .re   (cmd.undo_read),
    .raddr(top_dec),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      top_r   <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd.commit) begin
        total_r <= res_r;
        top_r   <= top_inc;
        if (fill_r != CW'(HISTORY_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end else if (cmd.undo_read) begin
        top_r  <= top_dec;
        fill_r <= fill_r - 1'b1;
      end else if (cmd.undo_load) begin
        total_r <= ram_rdata;
      end
    end
  end

  // Working registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd_r <= in_operand;
    end
    if (cmd.exec_add) begin
      res_r <= (sum_c[TOTAL_W] != sum_c[TOTAL_W-1]) ?
               (sum_c[TOTAL_W] ? T_MIN : T_MAX) : sum_c[TOTAL_W-1:0];
    end else if (cmd.exec_sub) begin
      res_r <= (dif_c[TOTAL_W] != dif_c[TOTAL_W-1]) ?
               (dif_c[TOTAL_W] ? T_MIN : T_MAX) : dif_c[TOTAL_W-1:0];
    end else if (cmd.mul_sat) begin
      res_r <= sat_mag(neg, prod_r >> FRAC_BITS);
    end else if (cmd.div_sat) begin
      res_r <= ovf_r ? (neg ? T_MIN : T_MAX)
                     : sat_mag(neg, {{(2*TOTAL_W-DIV_STEPS){1'b0}}, quo_r});
    end
    if (cmd.exec_mul) begin
      prod_r <= prod_c;
    end
    // A quotient of 2^31 or more saturates, so only 31 quotient bits are formed.
    if (cmd.div_init) begin
      rem_r  <= TOTAL_W'(num_hi);
      lo_r   <= num[DIV_STEPS-1:0];
      dmag_r <= mag_op;
      ovf_r  <= TOTAL_W'(num_hi) >= mag_op;
    end else if (cmd.div_step) begin
      rem_r <= ge ? TOTAL_W'(rem2 - dext) : rem2[TOTAL_W-1:0];
      lo_r  <= {lo_r[DIV_STEPS-2:0], 1'b0};
      quo_r <= {quo_r[DIV_STEPS-2:0], ge};
    end
    if (cmd.reply) begin
      otot_r  <= total_r;
      ostat_r <= cmd.reply_status;
      ocnt_r  <= COUNT_W'(fill_r);
    end
  end

  assign sts.opnd_zero  = (opnd_r == '0);
  assign sts.hist_empty = (fill_r == '0);

  assign out_total  = otot_r;
  assign out_status = ostat_r;
  assign out_count  = ocnt_r;

endmodule

>>> hdl/awu_ctrl.sv
// Controller: sequences each request through the datapath and owns both handshakes.
// Depends on awu_pkg.
`timescale 1ns / 1ps

module awu_ctrl import awu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [REQ_W-1:0] in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  awu_sts_t         sts,
  output awu_cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_MULSAT = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_DIVSAT = 8'b0001_0000,
    S_UNDO   = 8'b0010_0000,
    S_COMMIT = 8'b0100_0000,
    S_REPLY  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [REQ_W-1:0]    kind_r, kind_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  status_t             stat_r, stat_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic                accept, slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign slot_free  = !ovalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    cmd       = '0;
    cmd.reply_status = stat_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          kind_nxt  = in_tuser;
          stat_nxt  = ST_OK;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (kind_r)
          REQ_ADD: begin
            cmd.exec_add = 1'b1;
            state_nxt    = S_COMMIT;
          end
          REQ_SUB: begin
            cmd.exec_sub = 1'b1;
            state_nxt    = S_COMMIT;
          end
          REQ_MUL: begin
            cmd.exec_mul = 1'b1;
            state_nxt    = S_MULSAT;
          end
          REQ_DIV: begin
            if (sts.opnd_zero) begin
              stat_nxt  = ST_DIV_ZERO;
              state_nxt = S_REPLY;
            end else begin
              cmd.div_init = 1'b1;
              cnt_nxt      = DCNT_W'(DIV_STEPS - 1);
              state_nxt    = S_DIV;
            end
          end
          REQ_UNDO: begin
            if (sts.hist_empty) begin
              stat_nxt  = ST_UNDO_EMPTY;
              state_nxt = S_REPLY;
            end else begin
              cmd.undo_read = 1'b1;
              state_nxt     = S_UNDO;
            end
          end
          default: begin
            // Unknown request codes change nothing and report ok.
            state_nxt = S_REPLY;
          end
        endcase
      end
      S_MULSAT: begin
        cmd.mul_sat = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DIVSAT;
        end
      end
      S_DIVSAT: begin
        cmd.div_sat = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_UNDO: begin
        cmd.undo_load = 1'b1;
        state_nxt     = S_REPLY;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_REPLY;
      end
      S_REPLY: begin
        if (slot_free) begin
          cmd.reply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.reply) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      kind_r   <= '0;
      cnt_r    <= '0;
      stat_r   <= ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      kind_r   <= kind_nxt;
      cnt_r    <= cnt_nxt;
      stat_r   <= stat_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

>>> hdl/accumulator_with_undo_stack.sv
// Top level of the Q16.16 accumulator with undo history.
// Depends on awu_pkg, awu_ctrl and awu_datapath.
`timescale 1ns / 1ps
// The input channel takes one request word: in_tuser carries the request code
// (add, subtract, multiply, divide, undo) and in_tdata the signed operand.
// Each request gives exactly one result word on the output channel: the total
// after the request, a status code and the number of undoable entries held.
// One request is worked on at a time; in_tready is high only while the block is
// idle. Add and subtract pass an execute and a commit step, undo an execute and
// an undo step, multiply an execute, a saturate and a commit step, and divide an
// execute step, the restoring divider (one quotient bit a cycle), a saturate and
// a commit step; errors and unknown codes skip to the reply step that ends each
// request. The result word becomes valid in the cycle in which in_tready rises.
// The result stands in an output register, so the block takes the next request
// while a result still waits for out_tready; a new result waits in its final
// step until that register is free.
// Reset clears the total, the history pointer and the fill count; the history
// memory itself is not cleared, and no entry is read before it was written.

module accumulator_with_undo_stack import awu_pkg::*; #(
  parameter int HISTORY_DEPTH = 64,
  parameter int FRAC_BITS     = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // [31:0] operand
  input  logic [REQ_W-1:0] in_tuser,   // [2:0] req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata   // [31:0] running_total, [33:32] status,
                                       // [40:34] history_count, [47:41] zero
);

  awu_cmd_t           cmd;
  awu_sts_t           sts;
  logic [TOTAL_W-1:0] out_total;
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_count;

  awu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  awu_datapath #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_operand(in_tdata),
    .out_total (out_total),
    .out_status(out_status),
    .out_count (out_count)
  );

  assign out_tdata = {7'd0, out_count, out_status, out_total};

endmodule

>>> hdl/awu_checker.sv
// Port-level checks for the accumulator with undo history, bound to the top level.
// Depends on accumulator_with_undo_stack.
`timescale 1ns / 1ps

module awu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Requests are worked one at a time, so an accepted word closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken again right after a request");

  // A request word that waits for in_tready must stay as it was offered.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("waiting request word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:32] != 2'd3) && (out_tdata[47:41] == 7'd0))
    else $error("result word holds an unused status code or padding");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word offered right after reset");

endmodule

bind accumulator_with_undo_stack awu_checker u_awu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
